// ===== src/oaht_pkg.sv =====
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and constants for the open-address hash table: item layouts,
// command codes and default table size.
// ----------------------------------------------------------------------------
package oaht_pkg;

    localparam int TABLE_SLOTS_DEF = 64;
    localparam int KEY_W           = 31;
    localparam int COLL_W          = 7;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_SEARCH = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [COLL_W-1:0] collisions;
        logic              table_full;
    } rsp_t;

endpackage

// ===== src/oaht_mod.sv =====
// ----------------------------------------------------------------------------
// oaht_mod
// Home slot unit: key modulo the table size by multiplication with a fixed
// reciprocal, then one multiply-subtract for the remainder; the key, the
// product and the remainder are registered in turn before done rises.
// ----------------------------------------------------------------------------
module oaht_mod
    import oaht_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [KEY_W-1:0]               key,
    output logic                           done,
    output logic [$clog2(TABLE_SLOTS)-1:0] rem
);

    localparam int IDX_W  = $clog2(TABLE_SLOTS);
    localparam int SHIFT  = KEY_W + IDX_W;
    localparam int RCP_W  = KEY_W + 1;
    localparam int PROD_W = KEY_W + RCP_W;
    localparam int QUO_W  = PROD_W - SHIFT;
    localparam logic [63:0] RCP_WIDE =
        ((64'd1 << SHIFT) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);
    localparam logic [RCP_W-1:0] RCP       = RCP_WIDE[RCP_W-1:0];
    localparam logic [KEY_W-1:0] SLOTS_KEY = KEY_W'(TABLE_SLOTS);

    logic              load_reg;
    logic              mul_reg;
    logic              done_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [IDX_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  quo;
    logic [KEY_W-1:0]  quo_slots;
    logic [KEY_W-1:0]  diff;

    assign quo       = prod_reg[PROD_W-1:SHIFT];
    assign quo_slots = KEY_W'(quo) * SLOTS_KEY;
    assign diff      = key_reg - quo_slots;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= 1'b0;
            mul_reg  <= 1'b0;
            done_reg <= 1'b0;
            key_reg  <= '0;
            prod_reg <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            load_reg <= start;
            mul_reg  <= load_reg;
            done_reg <= mul_reg;
            if (start)
            begin
                key_reg <= key;
            end
            if (load_reg)
            begin
                prod_reg <= PROD_W'(key_reg) * PROD_W'(RCP);
            end
            if (mul_reg)
            begin
                rem_reg <= diff[IDX_W-1:0];
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== src/open_address_hash_table.sv =====
// ----------------------------------------------------------------------------
// open_address_hash_table
// Open-addressing hash table of 31-bit keys with linear or quadratic probing.
//
//   channel | signals                    | item
//   --------+----------------------------+---------------------------------
//   req     | req_valid, req_stall, req  | cmd (insert/search), key
//   rsp     | rsp_valid, rsp_stall, rsp  | found, collisions, table_full
//   cfg     | cfg_we, cfg_data           | probe_mode, written at once
//
// One item at a time: the remainder unit gives the home slot, then one probed
// slot per cycle (1 to TABLE_SLOTS) is read on the table memory's single
// read port, then the result is loaded into the output register once it is
// free; the next item is taken only after the block is back in idle.
// After reset a clearing pass writes every slot and wipes the occupied marks;
// req_stall stays high meanwhile. A stalled result waits in the output
// register while the next item is taken.
// ----------------------------------------------------------------------------
module open_address_hash_table
    import oaht_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp,
    input  logic cfg_we,
    input  logic cfg_data
);

    localparam int IDX_W  = $clog2(TABLE_SLOTS);
    localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
    localparam int WORD_W = KEY_W + 1;
    localparam logic [IDX_W:0]   SLOTS     = (IDX_W + 1)'(TABLE_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_SLOTS - 1);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TABLE_SLOTS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] dlt_reg, dlt_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    cmd_t             cmd_reg, cmd_next;
    logic [KEY_W-1:0] key_reg, key_next;
    rsp_t             res_reg, res_next;
    rsp_t             rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic             mode_reg, mode_next;

    logic [WORD_W-1:0] mem [TABLE_SLOTS];
    logic [WORD_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    logic             mod_start;
    logic             mod_done;
    logic [IDX_W-1:0] mod_rem;

    logic             occ;
    logic             hit;
    logic [CNT_W-1:0] cnt_inc;
    logic [IDX_W:0]   slot_sum;
    logic [IDX_W-1:0] slot_nxt;
    logic [IDX_W:0]   dlt_sum;
    logic [IDX_W-1:0] dlt_nxt;

    oaht_mod #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_mod (
        .clk  (clk),
        .rst_n(rst_n),
        .start(mod_start),
        .key  (req.key),
        .done (mod_done),
        .rem  (mod_rem)
    );

    assign occ     = rd_data_reg[KEY_W];
    assign hit     = occ && (rd_data_reg[KEY_W-1:0] == key_reg);
    assign cnt_inc = cnt_reg + CNT_W'(1);

    assign slot_sum = mode_reg ? ({1'b0, idx_reg} + {1'b0, dlt_reg})
                               : ({1'b0, idx_reg} + (IDX_W + 1)'(1));
    assign slot_nxt = (slot_sum >= SLOTS) ? IDX_W'(slot_sum - SLOTS) : IDX_W'(slot_sum);
    assign dlt_sum  = {1'b0, dlt_reg} + (IDX_W + 1)'(2);
    assign dlt_nxt  = (dlt_sum >= SLOTS) ? IDX_W'(dlt_sum - SLOTS) : IDX_W'(dlt_sum);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        idx_next       = idx_reg;
        dlt_next       = dlt_reg;
        cnt_next       = cnt_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        mode_next      = cfg_we ? cfg_data : mode_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = {1'b1, key_reg};
        mod_start      = 1'b0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + IDX_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next   = req.cmd;
                    key_next   = req.key;
                    mod_start  = 1'b1;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (mod_done)
                begin
                    idx_next   = mod_rem;
                    dlt_next   = IDX_W'(1);
                    cnt_next   = '0;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    if (!occ)
                    begin
                        mem_we     = 1'b1;
                        res_next   = '{found: 1'b0, collisions: COLL_W'(cnt_reg),
                                       table_full: 1'b0};
                        state_next = ST_FINISH;
                    end
                    else if (cnt_inc == SLOTS_CNT)
                    begin
                        res_next   = '{found: 1'b0, collisions: COLL_W'(cnt_inc),
                                       table_full: 1'b1};
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        idx_next = slot_nxt;
                        dlt_next = dlt_nxt;
                        cnt_next = cnt_inc;
                    end
                end
                else
                begin
                    if (hit)
                    begin
                        res_next   = '{found: 1'b1, collisions: '0, table_full: 1'b0};
                        state_next = ST_FINISH;
                    end
                    else if (!occ || (cnt_inc == SLOTS_CNT))
                    begin
                        res_next   = '{found: 1'b0, collisions: '0, table_full: 1'b0};
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        idx_next = slot_nxt;
                        dlt_next = dlt_nxt;
                        cnt_next = cnt_inc;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            idx_reg       <= '0;
            dlt_reg       <= '0;
            cnt_reg       <= '0;
            cmd_reg       <= CMD_INSERT;
            key_reg       <= '0;
            res_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            mode_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            idx_reg       <= idx_next;
            dlt_reg       <= dlt_next;
            cnt_reg       <= cnt_next;
            cmd_reg       <= cmd_next;
            key_reg       <= key_next;
            res_reg       <= res_next;
            rsp_reg       <= rsp_next;
            rsp_valid_reg <= rsp_valid_next;
            mode_reg      <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[idx_next];
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== src/oaht_checker.sv =====
// ----------------------------------------------------------------------------
// oaht_checker
// Port-level checks for the open-address hash table, bound to the top level.
// ----------------------------------------------------------------------------
module oaht_checker
    import oaht_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
)
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    localparam logic [COLL_W-1:0] FULL_COLL = COLL_W'(TABLE_SLOTS);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result item changed or dropped");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second item taken before the first was hashed");

    a_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.found |-> !rsp.table_full && (rsp.collisions == '0))
        else $error("search hit carries insert fields");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.table_full |-> !rsp.found && (rsp.collisions == FULL_COLL))
        else $error("full table reported with wrong collision count");

    a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !req_stall)
        else $error("result item presented while the table is still busy");

endmodule

bind open_address_hash_table oaht_checker #(
    .TABLE_SLOTS(TABLE_SLOTS)
) u_oaht_checker (.*);

// ===== tb/tb_open_address_hash_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_open_address_hash_table
// Self-checking bench for the open-address hash table. A short table of
// directed inserts and searches comes first. Random phases follow, each one
// switching the probe mode and the idling on both channels. Every result is
// compared, field by field, with a local model of the slot array, or for typed directed rows with the row's own want.
// ----------------------------------------------------------------------------
module tb_open_address_hash_table;
    import oaht_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int SLOTS         = TABLE_SLOTS_DEF;
    localparam int PHASE_ITEMS   = 135;
    localparam int SETTLE_CYCLES = 2 * (KEY_W + SLOTS + 2);
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam bit PROBE_LINEAR  = 1'b0;
    localparam bit PROBE_QUAD    = 1'b1;
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    typedef struct packed {
        bit   quad;
        req_t item;
        bit   typed;
        rsp_t want;
    } stim_row_t;

    typedef struct packed {
        bit         quad;
        logic [7:0] send_pct;
        logic [7:0] stall_pct;
        logic [7:0] insert_pct;
    } phase_t;

    localparam stim_row_t DIRECTED [21] = '{
        '{PROBE_LINEAR, '{CMD_SEARCH, 31'd0},          1'b1, '{1'b0, 7'd0, 1'b0}},
        '{PROBE_LINEAR, '{CMD_SEARCH, KEY_MAX},        1'b1, '{1'b0, 7'd0, 1'b0}},
        '{PROBE_LINEAR, '{CMD_INSERT, 31'd0},          1'b1, '{1'b0, 7'd0, 1'b0}},
        '{PROBE_LINEAR, '{CMD_INSERT, KEY_MAX},        1'b1, '{1'b0, 7'd0, 1'b0}},
        '{PROBE_LINEAR, '{CMD_INSERT, 31'd64},         1'b1, '{1'b0, 7'd1, 1'b0}},
        '{PROBE_LINEAR, '{CMD_INSERT, 31'd127},        1'b0, '{1'b0, 7'd0, 1'b0}},
        '{PROBE_LINEAR, '{CMD_SEARCH, 31'd0},          1'b1, '{1'b1, 7'd0, 1'b0}},
        '{PROBE_LINEAR, '{CMD_SEARCH, 31'd64},         1'b0, '{1'b0, 7'd0, 1'b0}},
        '{PROBE_LINEAR, '{CMD_SEARCH, 31'd127},        1'b0, '{1'b0, 7'd0, 1'b0}},
        '{PROBE_LINEAR, '{CMD_SEARCH, 31'd128},        1'b0, '{1'b0, 7'd0, 1'b0}},
        '{PROBE_LINEAR, '{CMD_INSERT, 31'd0},          1'b0, '{1'b0, 7'd0, 1'b0}},
        '{PROBE_LINEAR, '{CMD_SEARCH, 31'h5555_5555},  1'b0, '{1'b0, 7'd0, 1'b0}},
        '{PROBE_LINEAR, '{CMD_INSERT, 31'h2AAA_AAAA},  1'b0, '{1'b0, 7'd0, 1'b0}},
        '{PROBE_QUAD,   '{CMD_INSERT, 31'd191},        1'b0, '{1'b0, 7'd0, 1'b0}},
        '{PROBE_QUAD,   '{CMD_INSERT, 31'h7FFF_FFBF},  1'b0, '{1'b0, 7'd0, 1'b0}},
        '{PROBE_QUAD,   '{CMD_SEARCH, 31'd191},        1'b0, '{1'b0, 7'd0, 1'b0}},
        '{PROBE_QUAD,   '{CMD_SEARCH, 31'h7FFF_FFBF},  1'b0, '{1'b0, 7'd0, 1'b0}},
        '{PROBE_QUAD,   '{CMD_SEARCH, 31'd255},        1'b0, '{1'b0, 7'd0, 1'b0}},
        '{PROBE_QUAD,   '{CMD_INSERT, 31'd1},          1'b0, '{1'b0, 7'd0, 1'b0}},
        '{PROBE_QUAD,   '{CMD_SEARCH, 31'h2AAA_AAAA},  1'b0, '{1'b0, 7'd0, 1'b0}},
        '{PROBE_LINEAR, '{CMD_SEARCH, 31'd191},        1'b0, '{1'b0, 7'd0, 1'b0}}
    };

    localparam phase_t PHASES [8] = '{
        '{PROBE_QUAD,   8'd0,  8'd0,  8'd30},
        '{PROBE_LINEAR, 8'd69, 8'd0,  8'd20},
        '{PROBE_QUAD,   8'd0,  8'd69, 8'd15},
        '{PROBE_LINEAR, 8'd18, 8'd18, 8'd10},
        '{PROBE_LINEAR, 8'd0,  8'd0,  8'd8},
        '{PROBE_QUAD,   8'd69, 8'd0,  8'd8},
        '{PROBE_LINEAR, 8'd0,  8'd69, 8'd8},
        '{PROBE_QUAD,   8'd18, 8'd18, 8'd8}
    };

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;
    logic cfg_we    = 1'b0;
    logic cfg_data  = 1'b0;

    logic [KEY_W-1:0] slot_key [SLOTS];
    bit               slot_used [SLOTS];
    bit               probe_quad = PROBE_LINEAR;
    rsp_t             expected_rsp_q [$];
    logic [KEY_W-1:0] inserted_keys [$];
    int               fail_count    = 0;
    int               cycle_count   = 0;
    int               send_idle_pct = 0;
    int               stall_pct     = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    open_address_hash_table #(
        .TABLE_SLOTS (SLOTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    function automatic int probe_next(input int cur, input int home, input int step);
        if (probe_quad == PROBE_QUAD)
            return (home + step * step) % SLOTS;
        return (cur + 1) % SLOTS;
    endfunction

    function automatic rsp_t hash_table_apply(input req_t item);
        int   home;
        int   idx;
        int   step;
        int   count;
        rsp_t res;
        home  = int'(item.key) % SLOTS;
        idx   = home;
        step  = 1;
        count = 0;
        res   = '0;
        if (item.cmd == CMD_INSERT)
        begin
            while (slot_used[idx] && count < SLOTS)
            begin
                count++;
                idx = probe_next(idx, home, step);
                step++;
            end
            res.table_full = (count >= SLOTS);
            res.collisions = COLL_W'(count);
            if (!res.table_full)
            begin
                slot_key[idx]  = item.key;
                slot_used[idx] = 1'b1;
            end
        end
        else
        begin
            while (slot_used[idx] && !res.found && count < SLOTS)
            begin
                if (slot_key[idx] == item.key)
                    res.found = 1'b1;
                else
                begin
                    idx = probe_next(idx, home, step);
                    step++;
                    count++;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic push_request(input req_t item, input bit typed, input rsp_t want);
        rsp_t modelled;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        modelled = hash_table_apply(item);
        expected_rsp_q.push_back(typed ? want : modelled);
        if (item.cmd == CMD_INSERT)
            inserted_keys.push_back(item.key);
    endtask

    task automatic set_probe_mode(input bit quad);
        req_valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= quad;
        @(posedge clk);
        cfg_we     <= 1'b0;
        probe_quad  = quad;
    endtask

    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                    report_mismatch("item with nothing expected", int'(rsp), 0);
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.found !== want.found)
                        report_mismatch("found", int'(rsp.found), int'(want.found));
                    if (rsp.collisions !== want.collisions)
                        report_mismatch("collisions", int'(rsp.collisions),
                                        int'(want.collisions));
                    if (rsp.table_full !== want.table_full)
                        report_mismatch("table_full", int'(rsp.table_full),
                                        int'(want.table_full));
                end
            end
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        stim_row_t row;
        phase_t    ph;
        req_t      item;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
        begin
            row = DIRECTED[i];
            if (row.quad != probe_quad)
                set_probe_mode(row.quad);
            push_request(row.item, row.typed, row.want);
        end

        foreach (PHASES[p])
        begin
            ph = PHASES[p];
            set_probe_mode(ph.quad);
            send_idle_pct = int'(ph.send_pct);
            stall_pct     = int'(ph.stall_pct);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                item.cmd = ($urandom_range(0, 99) < ph.insert_pct) ? CMD_INSERT : CMD_SEARCH;
                case ($urandom_range(0, 9))
                    0, 1, 2:
                        item.key = KEY_W'($urandom);
                    3, 4, 5:
                        // crowd a few home slots either side of the wrap
                        item.key = KEY_W'(KEY_W'($urandom) / SLOTS * SLOTS
                                 + ($urandom_range(SLOTS - 4, SLOTS + 3) % SLOTS));
                    6, 7, 8:
                        if (inserted_keys.size() != 0)
                            item.key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
                        else
                            item.key = KEY_W'($urandom);
                    default:
                        case ($urandom_range(0, 3))
                            0:       item.key = '0;
                            1:       item.key = KEY_MAX;
                            2:       item.key = KEY_W'(SLOTS - 1);
                            default: item.key = KEY_MAX - KEY_W'(SLOTS);
                        endcase
                endcase
                push_request(item, 1'b0, '0);
            end
        end

        req_valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== open_address_hash_table.f =====
src/oaht_pkg.sv
src/oaht_mod.sv
src/open_address_hash_table.sv
src/oaht_checker.sv
tb/tb_open_address_hash_table.sv
